### hdl/handle_table_with_compaction_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the handle table
// Clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HANDLE_TABLE_WITH_COMPACTION_DEFINES_SVH
`define HANDLE_TABLE_WITH_COMPACTION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/htc_pkg.sv
// ---------------------------------------------------------------------------
// htc_pkg
// Shared types, codes and default sizes of the handle table.
// ---------------------------------------------------------------------------
`default_nettype none

package htc_pkg;

    localparam int HTC_SLOT_DEPTH   = 256;
    localparam int HTC_HANDLE_DEPTH = 1024;
    localparam int HTC_OBJECT_BITS  = 32;

    localparam int HTC_FUNC_W   = 2;
    localparam int HTC_STATUS_W = 2;

    typedef enum logic [HTC_FUNC_W-1:0] {
        FUNC_CREATE  = 2'd0,
        FUNC_GET     = 2'd1,
        FUNC_DESTROY = 2'd2
    } t_func;

    typedef enum logic [HTC_STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_GET,
        ST_SHIFT,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

### hdl/htc_in_if.sv
// ---------------------------------------------------------------------------
// htc_in_if
// Request channel: operation, handle and object word with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface htc_in_if
    import htc_pkg::*;
#(
    parameter int HANDLE_DEPTH = HTC_HANDLE_DEPTH,
    parameter int OBJECT_BITS  = HTC_OBJECT_BITS
) ();

    localparam int HW = $clog2(HANDLE_DEPTH);

    logic                   valid;
    logic                   ready;
    logic [HTC_FUNC_W-1:0]  func;
    logic [HW-1:0]          handle_in;
    logic [OBJECT_BITS-1:0] object_word;

    modport source (output valid, func, handle_in, object_word, input ready);
    modport sink   (input valid, func, handle_in, object_word, output ready);

endinterface

`default_nettype wire

### hdl/htc_out_if.sv
// ---------------------------------------------------------------------------
// htc_out_if
// Response channel: handle, object word and status with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface htc_out_if
    import htc_pkg::*;
#(
    parameter int HANDLE_DEPTH = HTC_HANDLE_DEPTH,
    parameter int OBJECT_BITS  = HTC_OBJECT_BITS
) ();

    localparam int HW = $clog2(HANDLE_DEPTH);

    logic                    valid;
    logic                    ready;
    logic [HW-1:0]           handle_out;
    logic [OBJECT_BITS-1:0]  object_out;
    logic [HTC_STATUS_W-1:0] status;

    modport source (output valid, handle_out, object_out, status, input ready);
    modport sink   (input valid, handle_out, object_out, status, output ready);

endinterface

`default_nettype wire

### hdl/handle_table_with_compaction.sv
// ---------------------------------------------------------------------------
// handle_table_with_compaction - stable-handle registry with dense slot store
// Create is resolved in LOOK, get in GET after LOOK, destroy in SHIFT after
// LOOK, where SHIFT moves each slot above the removed one down one place.
// A new request is taken only after the previous one has finished; the slot
// memory's single read port moves one slot per cycle during compaction.
// Reset clears slot count, handle counter, FSM and output valid; the memories
// are not cleared (entries are only read once written).
// ---------------------------------------------------------------------------
`default_nettype none

`include "handle_table_with_compaction_defines.svh"

module handle_table_with_compaction
    import htc_pkg::*;
#(
    parameter int SLOT_DEPTH   = HTC_SLOT_DEPTH,
    parameter int HANDLE_DEPTH = HTC_HANDLE_DEPTH,
    parameter int OBJECT_BITS  = HTC_OBJECT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    htc_in_if.sink     i_in,
    htc_out_if.source  o_out
);

    // Widths: slot address, slot count (holds SLOT_DEPTH as the dead mark),
    // handle address, handle counter, slot memory word {owner, object}.
    localparam int SIW = $clog2(SLOT_DEPTH);
    localparam int SCW = $clog2(SLOT_DEPTH + 1);
    localparam int HW  = $clog2(HANDLE_DEPTH);
    localparam int HCW = $clog2(HANDLE_DEPTH + 1);
    localparam int SWW = HW + OBJECT_BITS;

    localparam logic [SCW-1:0] DEAD_SLOT    = SCW'(SLOT_DEPTH);
    localparam logic [HCW-1:0] FULL_HANDLES = HCW'(HANDLE_DEPTH);

    // Memories. Slot store keeps owner handle above the object word; the
    // handle map gives the current slot of each issued handle.
    logic [SWW-1:0] r_slot_mem [SLOT_DEPTH];
    logic [SCW-1:0] r_map_mem  [HANDLE_DEPTH];

    // Control state
    t_state           r_state, n_state;
    logic [SCW-1:0]   r_count, n_count;
    logic [HCW-1:0]   r_issued, n_issued;
    logic [SCW-1:0]   r_ptr, n_ptr;
    logic             r_pend, n_pend;
    logic             r_out_valid;

    // Transaction held while it is worked on
    t_func                  r_func;
    logic [HW-1:0]          r_handle;
    logic [OBJECT_BITS-1:0] r_object;
    logic [SIW-1:0]         r_wr_idx, n_wr_idx;

    // Registered memory read data
    logic [SCW-1:0] r_map_rd;
    logic [SWW-1:0] r_slot_rd;

    // Result parked while the output register is still occupied
    logic [HW-1:0]          r_res_handle;
    logic [OBJECT_BITS-1:0] r_res_object;
    t_status                r_res_status;

    // Output register
    logic [HW-1:0]          r_out_handle;
    logic [OBJECT_BITS-1:0] r_out_object;
    t_status                r_out_status;

    // Combinational datapath
    logic                   w_accept;
    logic                   w_live;
    logic                   w_full;
    logic                   w_out_free;
    logic                   w_shift_issue;
    logic                   w_shift_done;
    logic                   w_fin;
    logic [HW-1:0]          w_res_handle;
    logic [OBJECT_BITS-1:0] w_res_object;
    t_status                w_res_status;
    logic [SIW-1:0]         w_slot_rd_addr;
    logic                   w_slot_we;
    logic [SIW-1:0]         w_slot_wr_addr;
    logic [SWW-1:0]         w_slot_wr_data;
    logic                   w_map_we;
    logic [HW-1:0]          w_map_wr_addr;
    logic [SCW-1:0]         w_map_wr_data;

    // One transaction in flight; new requests only in IDLE. The output
    // register decouples the response side, so a request is taken while the
    // previous response still waits.
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // A handle is live if it was issued and its map entry is below the slot
    // count; destroyed handles carry the dead mark, which never is.
    assign w_live = (HCW'(r_handle) < r_issued) && (r_map_rd < r_count);
    assign w_full = (r_count >= DEAD_SLOT) || (r_issued >= FULL_HANDLES);

    // Compaction walk: read slot r_ptr, write it one place down next cycle.
    assign w_shift_issue = (r_state == ST_SHIFT) && (r_ptr < r_count);
    assign w_shift_done  = (r_state == ST_SHIFT) && !w_shift_issue && !r_pend;

    // ---------------------------------------------------------------- FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if ((r_func == FUNC_GET) && w_live) begin
                    n_state = ST_GET;
                end else if ((r_func == FUNC_DESTROY) && w_live) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = w_out_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_GET: begin
                n_state = w_out_free ? ST_IDLE : ST_RESP;
            end
            ST_SHIFT: begin
                if (w_shift_done) begin
                    n_state = w_out_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------- datapath and writes
    always_comb begin
        n_count        = r_count;
        n_issued       = r_issued;
        n_ptr          = r_ptr;
        n_pend         = 1'b0;
        n_wr_idx       = r_wr_idx;
        w_fin          = 1'b0;
        w_res_handle   = r_handle;
        w_res_object   = '0;
        w_res_status   = STATUS_OK;
        w_slot_rd_addr = r_ptr[SIW-1:0];
        w_slot_we      = 1'b0;
        w_slot_wr_addr = r_count[SIW-1:0];
        w_slot_wr_data = {r_issued[HW-1:0], r_object};
        w_map_we       = 1'b0;
        w_map_wr_addr  = r_issued[HW-1:0];
        w_map_wr_data  = r_count;
        case (r_state)
            ST_LOOK: begin
                case (r_func)
                    FUNC_CREATE: begin
                        w_fin = 1'b1;
                        if (w_full) begin
                            w_res_handle = '0;
                            w_res_status = STATUS_FULL;
                        end else begin
                            // append at the top of the store, issue next handle
                            w_slot_we    = 1'b1;
                            w_map_we     = 1'b1;
                            n_count      = SCW'(r_count + 1'b1);
                            n_issued     = HCW'(r_issued + 1'b1);
                            w_res_handle = r_issued[HW-1:0];
                        end
                    end
                    FUNC_GET: begin
                        w_slot_rd_addr = r_map_rd[SIW-1:0];
                        if (!w_live) begin
                            w_fin        = 1'b1;
                            w_res_status = STATUS_BAD;
                        end
                    end
                    FUNC_DESTROY: begin
                        n_ptr = SCW'(r_map_rd + 1'b1);
                        if (!w_live) begin
                            w_fin        = 1'b1;
                            w_res_status = STATUS_BAD;
                        end
                    end
                    default: begin
                        w_fin        = 1'b1;
                        w_res_status = STATUS_BAD;
                    end
                endcase
            end
            ST_GET: begin
                w_fin        = 1'b1;
                w_res_object = r_slot_rd[OBJECT_BITS-1:0];
            end
            ST_SHIFT: begin
                if (w_shift_issue) begin
                    n_ptr    = SCW'(r_ptr + 1'b1);
                    n_pend   = 1'b1;
                    n_wr_idx = SIW'(r_ptr - 1'b1);
                end
                if (r_pend) begin
                    // moved slot's owner now lives one place lower
                    w_slot_we      = 1'b1;
                    w_slot_wr_addr = r_wr_idx;
                    w_slot_wr_data = r_slot_rd;
                    w_map_we       = 1'b1;
                    w_map_wr_addr  = r_slot_rd[SWW-1 -: HW];
                    w_map_wr_data  = SCW'(r_wr_idx);
                end else if (w_shift_done) begin
                    w_map_we      = 1'b1;
                    w_map_wr_addr = r_handle;
                    w_map_wr_data = DEAD_SLOT;
                    n_count       = SCW'(r_count - 1'b1);
                    w_fin         = 1'b1;
                end
            end
            ST_RESP: begin
                w_fin        = 1'b1;
                w_res_handle = r_res_handle;
                w_res_object = r_res_object;
                w_res_status = r_res_status;
            end
            default: begin
                w_fin = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------ memories
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_wr_addr] <= w_slot_wr_data;
        end
        r_slot_rd <= r_slot_mem[w_slot_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_map_wr_addr] <= w_map_wr_data;
        end
        if (w_accept) begin
            r_map_rd <= r_map_mem[i_in.handle_in];
        end
    end

    // ----------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issued    <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issued <= n_issued;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            if (w_fin && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        r_wr_idx <= n_wr_idx;
        if (w_accept) begin
            r_func   <= t_func'(i_in.func);
            r_handle <= i_in.handle_in;
            r_object <= i_in.object_word;
        end
        if (w_fin && w_out_free) begin
            r_out_handle <= w_res_handle;
            r_out_object <= w_res_object;
            r_out_status <= w_res_status;
        end
        if (w_fin && !w_out_free) begin
            r_res_handle <= w_res_handle;
            r_res_object <= w_res_object;
            r_res_status <= w_res_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.handle_out = r_out_handle;
    assign o_out.object_out = r_out_object;
    assign o_out.status     = r_out_status;

    // ---------------------------------------------------------- assertions
    `HTC_ASSERT_NXT(a_accept_look, w_accept, r_state == ST_LOOK, "transaction skipped lookup")
    `HTC_ASSERT_NXT(a_create_counts, (r_state == ST_LOOK) && (r_func == FUNC_CREATE) && !w_full, (r_count == SCW'($past(r_count) + 1'b1)) && (r_issued == HCW'($past(r_issued) + 1'b1)), "create did not advance counters")
    `HTC_ASSERT_NXT(a_destroy_count, w_shift_done, r_count == SCW'($past(r_count) - 1'b1), "destroy did not shrink store")
    `HTC_ASSERT_IMP(a_shift_order, r_pend, SCW'(r_wr_idx) < r_ptr, "compaction write overtook read")

endmodule

`default_nettype wire
